@@ hdl/averaged_perceptron_weight_engine_defines.svh @@
// Assertion macros for the averaged perceptron weight engine.
`ifndef AVERAGED_PERCEPTRON_WEIGHT_ENGINE_DEFINES_SVH
`define AVERAGED_PERCEPTRON_WEIGHT_ENGINE_DEFINES_SVH

// Check a consequence in the same cycle.
`define APWE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle.
`define APWE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/apwe_pkg.sv @@
// Types, codes and saturating arithmetic shared by the weight engine modules.
package apwe_pkg;

	localparam int ITER_W = 24;
	localparam int WEIGHT_W = 32;
	localparam int ACC_W = 64;

	localparam logic [1:0] KIND_UPDATE = 2'd0;
	localparam logic [1:0] KIND_SCORE = 2'd1;
	localparam logic [1:0] KIND_ADVANCE = 2'd2;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	typedef struct packed {
		logic en;
		logic [WEIGHT_W-1:0] weight;
		logic [ACC_W-1:0] acc;
	} apwe_wr_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [ACC_W-1:0] acc;
	} apwe_rd_t;

	typedef struct packed {
		logic clip;
		logic [ACC_W-1:0] value;
	} sat64_t;

	function automatic sat64_t sat_add64(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
		sat64_t r;
		logic [ACC_W-1:0] s;
		s = a + b;
		r.clip = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
		r.value = r.clip ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
		return r;
	endfunction

endpackage

@@ hdl/apwe_mem.sv @@
// Weight and accumulator memories with the post-reset clearing sweep.
module apwe_mem #(
	parameter int DEPTH = 32768,
	parameter int AW = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [AW-1:0] rd_addr,
	output apwe_pkg::apwe_rd_t rd_data,
	input  logic [AW-1:0] wr_addr,
	input  apwe_pkg::apwe_wr_t wr,
	output logic clearing
);
	import apwe_pkg::*;

	logic [WEIGHT_W-1:0] wmem [DEPTH];
	logic [ACC_W-1:0] amem [DEPTH];

	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic we;
	logic [AW-1:0] wa;
	logic [WEIGHT_W-1:0] wd_weight;
	logic [ACC_W-1:0] wd_acc;
	logic [WEIGHT_W-1:0] rd_weight_q;
	logic [ACC_W-1:0] rd_acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign we = clr_busy_q || wr.en;
	assign wa = clr_busy_q ? clr_addr_q : wr_addr;
	assign wd_weight = clr_busy_q ? '0 : wr.weight;
	assign wd_acc = clr_busy_q ? '0 : wr.acc;

	always_ff @(posedge clk) begin
		if (we) begin
			wmem[wa] <= wd_weight;
		end
		rd_weight_q <= wmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			amem[wa] <= wd_acc;
		end
		rd_acc_q <= amem[rd_addr];
	end

	assign rd_data.weight = rd_weight_q;
	assign rd_data.acc = rd_acc_q;
	assign clearing = clr_busy_q;

endmodule

@@ hdl/averaged_perceptron_weight_engine.sv @@
// Averaged perceptron weight engine: weight/accumulator tables, update, scoring, iteration count.
// After reset the block sweeps both tables to zero, one entry per cycle, over NUM_TAGS *
// NUM_TEMPLATES * NUM_FEATURE_IDS entries (32768 with the defaults), and takes no item until the
// sweep ends. An update or score item then goes through these steps in order: the address is
// registered, the synchronous memory is read, the weight add and the iteration-by-change multiply
// are done, and then the accumulator add, the write-back and the running sum. An advance item,
// kind 3 and an update with an absent or out-of-range feature are handled in the idle state. A
// finished sum waits in an output register, so items keep entering while it waits; only a score
// item that ends a vector stalls in its done state while an earlier sum is still untaken.
`include "averaged_perceptron_weight_engine_defines.svh"
module averaged_perceptron_weight_engine #(
	parameter int NUM_TAGS = 16,
	parameter int NUM_TEMPLATES = 8,
	parameter int NUM_FEATURE_IDS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic [1:0] kind,
	input  logic [3:0] tag,
	input  logic [2:0] template_index,
	input  logic signed [8:0] feature_id,
	input  logic signed [31:0] change,
	input  logic use_averaged,
	input  logic last,
	output logic result_valid,
	input  logic result_ready,
	output logic signed [63:0] score_sum,
	output logic saturated
);
	import apwe_pkg::*;

	localparam int DEPTH = NUM_TAGS * NUM_TEMPLATES * NUM_FEATURE_IDS;
	localparam int AW = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [ITER_W-1:0] iter_q;
	logic [ACC_W-1:0] run_q;
	logic clip_q;
	logic result_valid_q;
	logic [ACC_W-1:0] score_sum_q;
	logic saturated_q;

	logic [1:0] kind_s1;
	logic [WEIGHT_W-1:0] change_s1;
	logic use_avg_s1;
	logic last_s1;
	logic loc_s1;
	logic [AW-1:0] addr_s1;

	logic [WEIGHT_W-1:0] weight_s2;
	logic signed [56:0] prod_s2;
	logic [ACC_W-1:0] acc_s2;
	logic [ACC_W-1:0] val_s2;

	logic accept;
	logic loc_ok;
	logic [31:0] addr_full;
	logic clearing;
	apwe_rd_t rd_data;
	apwe_wr_t wr;
	logic signed [WEIGHT_W:0] wsum;
	logic [WEIGHT_W-1:0] wnew;
	logic signed [56:0] prod;
	sat64_t acc_new;
	sat64_t sum_new;
	logic emit;
	logic stall;

	apwe_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(addr_s1),
		.rd_data(rd_data),
		.wr_addr(addr_s1),
		.wr(wr),
		.clearing(clearing)
	);

	assign item_ready = !clearing && (state_q == ST_IDLE);
	assign accept = item_valid && item_ready;

	assign loc_ok = !feature_id[8]
		&& (32'(tag) < 32'(NUM_TAGS))
		&& (32'(template_index) < 32'(NUM_TEMPLATES))
		&& (32'(feature_id[7:0]) < 32'(NUM_FEATURE_IDS));
	assign addr_full = (32'(tag) * 32'(NUM_TEMPLATES) + 32'(template_index))
		* 32'(NUM_FEATURE_IDS) + 32'(feature_id[7:0]);

	assign wsum = {rd_data.weight[WEIGHT_W-1], rd_data.weight}
		+ {change_s1[WEIGHT_W-1], change_s1};
	assign wnew = (wsum[WEIGHT_W] != wsum[WEIGHT_W-1])
		? (wsum[WEIGHT_W] ? WEIGHT_MIN : WEIGHT_MAX) : wsum[WEIGHT_W-1:0];
	assign prod = $signed({1'b0, iter_q}) * $signed(change_s1);

	assign acc_new = sat_add64(acc_s2, {{(ACC_W-57){prod_s2[56]}}, prod_s2});
	assign sum_new = sat_add64(run_q, val_s2);

	assign emit = (state_q == ST_DONE) && (kind_s1 == KIND_SCORE) && last_s1;
	assign stall = emit && result_valid_q && !result_ready;

	assign wr.en = (state_q == ST_DONE) && (kind_s1 == KIND_UPDATE);
	assign wr.weight = weight_s2;
	assign wr.acc = acc_new.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= ITER_W'(1);
			run_q <= '0;
			clip_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit && !stall) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_ADVANCE) begin
							if (iter_q != {ITER_W{1'b1}}) begin
								iter_q <= iter_q + 1'b1;
							end
						end else if (kind == KIND_SCORE || (kind == KIND_UPDATE && loc_ok)) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (kind_s1 == KIND_SCORE && !stall) begin
						if (last_s1) begin
							run_q <= '0;
							clip_q <= 1'b0;
						end else begin
							run_q <= sum_new.value;
							clip_q <= clip_q || sum_new.clip;
						end
					end
					if (!stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			change_s1 <= change;
			use_avg_s1 <= use_averaged;
			last_s1 <= last;
			loc_s1 <= loc_ok;
			addr_s1 <= loc_ok ? addr_full[AW-1:0] : '0;
		end
		if (state_q == ST_CALC) begin
			weight_s2 <= wnew;
			prod_s2 <= prod;
			acc_s2 <= rd_data.acc;
			if (!loc_s1) begin
				val_s2 <= '0;
			end else if (use_avg_s1) begin
				val_s2 <= rd_data.acc;
			end else begin
				val_s2 <= {{(ACC_W-WEIGHT_W){rd_data.weight[WEIGHT_W-1]}}, rd_data.weight};
			end
		end
		if (emit && !stall) begin
			score_sum_q <= sum_new.value;
			saturated_q <= clip_q || sum_new.clip;
		end
	end

	assign result_valid = result_valid_q;
	assign score_sum = score_sum_q;
	assign saturated = saturated_q;

	`APWE_ASSERT_NOW(a_no_item_while_clearing, clearing, !item_ready, "item taken during clearing sweep")
	`APWE_ASSERT_NOW(a_write_only_at_writeback, wr.en, !clearing && state_q == ST_DONE && kind_s1 == KIND_UPDATE, "table write outside write-back")
	`APWE_ASSERT_NEXT(a_sum_cleared_after_emit, emit && !stall, run_q == '0 && !clip_q && result_valid, "running sum not cleared after emit")
	`APWE_ASSERT_NEXT(a_iter_advance, accept && kind == KIND_ADVANCE && iter_q != {ITER_W{1'b1}}, iter_q == $past(iter_q) + 1'b1, "iteration count did not advance")

endmodule
